[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fftx_pkg.sv]
// ----------------------------------------------------------------------------
// fftx_pkg
// shared constants and types of the fifo fed serial transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package fftx_pkg;

  localparam int unsigned QueueDepth = 1024;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned FillW      = 11;
  localparam int unsigned ResultW    = FillW + 3;
  localparam int unsigned OutDataW   = ((ResultW + 7) / 8) * 8;

  localparam logic [3:0] FrameBits = 4'd10;

  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef struct packed {
    logic       tick;
    logic       load;
    logic       bypass;
    logic [7:0] byte_val;
  } ser_ctl_t;

  typedef struct packed {
    logic             sending;
    logic [FillW-1:0] fill_count;
    logic             byte_dropped;
    logic             line_level;
  } result_t;

endpackage

`default_nettype wire

[rtl/fifo_fed_serial_transmitter.sv]
// ----------------------------------------------------------------------------
// fifo_fed_serial_transmitter
// byte queue feeding an 8n1 serializer, one status beat per input beat
// ----------------------------------------------------------------------------
// input channel: s_axis_tuser_i selects the beat kind (0 = byte arrives,
// 1 = one bit-period tick), s_axis_tdata_i carries the byte.
// output channel: one beat per input beat with the line level, the drop flag,
// the fill count after the beat and the sending flag.
// every input beat is handled in the cycle it is accepted; the status beat is
// registered and appears on the output in the cycle after acceptance, and a new
// input beat can be taken every cycle unless the output stalls. the rate is set
// by the single write and read port of the 1024 byte queue memory and the one
// read-modify-write of its pointers per beat. a byte loaded from the queue is
// read from memory into the read data register in the beat that loads it and
// then taken into the shift register, ahead of its first data bit; a byte that
// arrives to an empty queue and idle serializer is loaded directly.
// reset empties the queue and idles the line high; queue contents are not
// cleared. while the output beat is held by a stalled receiver, the input
// side stalls as well.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_fed_serial_transmitter import fftx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // data_byte[7:0]
  input  logic                s_axis_tuser_i,  // operation
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // line_level, byte_dropped,
                                               // fill_count[10:0], sending
);

  logic              in_fire, is_tick, push_req, push, pop, full, empty, idle_nx;
  logic              line_nx, sending_nx;
  logic [7:0]        rdata;
  logic [CountW-1:0] count_nx;
  ser_ctl_t          ser_ctl;
  result_t           res_q;
  logic              out_valid_q, out_valid_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_tick         = (op_e'(s_axis_tuser_i) == OpTick);
  assign push_req        = in_fire && !is_tick;
  assign push            = push_req && !full;
  assign pop             = in_fire && idle_nx && (!empty || push);

  always_comb begin
    ser_ctl.tick     = in_fire && is_tick;
    ser_ctl.load     = pop;
    ser_ctl.bypass   = empty;
    ser_ctl.byte_val = s_axis_tdata_i;
  end

  fftx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (s_axis_tdata_i),
    .pop_i   (pop),
    .rdata_o (rdata),
    .count_o (count_nx),
    .full_o  (full),
    .empty_o (empty)
  );

  fftx_ser u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ser_ctl),
    .rdata_i   (rdata),
    .idle_nx_o (idle_nx),
    .line_o    (line_nx),
    .sending_o (sending_nx)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q.line_level   <= line_nx;
      res_q.byte_dropped <= push_req && full;
      res_q.fill_count   <= FillW'(count_nx);
      res_q.sending      <= sending_nx;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - ResultW)'(0), res_q};

endmodule

`default_nettype wire

[rtl/fftx_fifo.sv]
// ----------------------------------------------------------------------------
// fftx_fifo
// byte ring buffer in a synchronous memory with pointer and fill bookkeeping
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fftx_fifo import fftx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        wdata_i,
  input  logic              pop_i,
  output logic [7:0]        rdata_o,
  output logic [CountW-1:0] count_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [7:0]        mem_q [QueueDepth];
  logic [7:0]        rdata_q;
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(QueueDepth - 1);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
    end
    count_d = count_q + CountW'(push_i) - CountW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_d;
  assign full_o  = (count_q == CountW'(QueueDepth));
  assign empty_o = (count_q == '0);

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CountW'(QueueDepth))
  `ASSERT_IMPLY(a_pop_empty_bypass, clk_i, rst_ni, pop_i && empty_o, push_i)

endmodule

`default_nettype wire

[rtl/fftx_ser.sv]
// ----------------------------------------------------------------------------
// fftx_ser
// 8n1 frame serializer with deferred load of the memory read data
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fftx_ser import fftx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ser_ctl_t   ctl_i,
  input  logic [7:0] rdata_i,
  output logic       idle_nx_o,
  output logic       line_o,
  output logic       sending_o
);

  logic [3:0] bits_q, bits_d, bits_t;
  logic [7:0] shift_q, shift_d, shift_t;
  logic       line_q, line_d;
  logic       pend_q, pend_d;

  always_comb begin
    bits_t  = bits_q;
    shift_t = shift_q;
    line_d  = line_q;
    if (pend_q) begin
      shift_t = rdata_i;
    end
    if (ctl_i.tick) begin
      priority if (bits_q == '0) begin
        line_d = 1'b1;
      end else if (bits_q == 4'd1) begin
        line_d = 1'b1;
        bits_t = '0;
      end else if (bits_q == FrameBits) begin
        line_d = 1'b0;
        bits_t = bits_q - 4'd1;
      end else begin
        line_d  = shift_q[0];
        shift_t = {1'b0, shift_q[7:1]};
        bits_t  = bits_q - 4'd1;
      end
    end
  end

  assign idle_nx_o = (bits_t == '0);

  always_comb begin
    bits_d  = bits_t;
    shift_d = shift_t;
    pend_d  = 1'b0;
    if (ctl_i.load) begin
      bits_d = FrameBits;
      if (ctl_i.bypass) begin
        shift_d = ctl_i.byte_val;
      end else begin
        pend_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      shift_q <= '0;
      line_q  <= 1'b1;
      pend_q  <= 1'b0;
    end else begin
      bits_q  <= bits_d;
      shift_q <= shift_d;
      line_q  <= line_d;
      pend_q  <= pend_d;
    end
  end

  assign line_o    = line_d;
  assign sending_o = (bits_d != '0);

  `ASSERT_ALWAYS(a_bits_bound, clk_i, rst_ni, bits_q <= FrameBits)
  `ASSERT_IMPLY(a_idle_line_high, clk_i, rst_ni, bits_q == '0, line_q)
  `ASSERT_IMPLY(a_pend_at_start, clk_i, rst_ni, pend_q, bits_q == FrameBits)

endmodule

`default_nettype wire
